### rtl/core/sparse_polynomial_term_store_core_assert.svh
// Assertion macros for the term store core
`ifndef SPARSE_POLYNOMIAL_TERM_STORE_CORE_ASSERT_SVH
`define SPARSE_POLYNOMIAL_TERM_STORE_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define SPTS_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset
`define SPTS_ASSERT_NXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

### rtl/core/spts_pkg.sv
`timescale 1ns / 1ps
package spts_pkg;
	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_EVAL  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_POW,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;
endpackage

### rtl/core/sparse_polynomial_term_store_core.sv
`timescale 1ns / 1ps
// Sparse polynomial term store. NUM_POLYS tables of up to MAX_TERMS terms,
// sorted by falling exponent, live in one term memory (coefficient and
// exponent per entry) with registered read. One item is processed
// at a time. Add term: one memory read per term scanned, and on insert or
// removal one read and one write per entry moved. Evaluate: per term one
// read, then square-and-multiply over EXPO_BITS exponent bits with a shared
// registered multiplier (two multiplies per bit), then a coefficient multiply
// and accumulate. Clear and other items go from the scan state straight to
// the done state. The result sits in an output register; the next item is
// taken once that register is free.
module sparse_polynomial_term_store_core #(
	parameter int NUM_POLYS = 32,
	parameter int MAX_TERMS = 16,
	parameter int EXPO_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: poly_sel[4:0], coef[36:5], expo[44:37], x[76:45], zero fill to 80
	input  logic [79:0] s_tdata,
	// tuser: func[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: value[31:0], term_count[36:32], status[37], zero fill to 40
	output logic [39:0] m_tdata
);
	import spts_pkg::*;
	`include "sparse_polynomial_term_store_core_assert.svh"

	localparam int PB = (NUM_POLYS > 1) ? $clog2(NUM_POLYS) : 1;
	localparam int TB = $clog2(MAX_TERMS);
	localparam int CB = $clog2(MAX_TERMS + 1);
	localparam int AB = PB + TB;
	localparam int DEPTH = NUM_POLYS * MAX_TERMS;
	localparam int EB = (EXPO_BITS > 1) ? $clog2(EXPO_BITS) : 1;

	// Term memory and per-polynomial count
	logic [31:0]          coef_mem [DEPTH];
	logic [EXPO_BITS-1:0] expo_mem [DEPTH];
	logic [CB-1:0]        cnt_q    [NUM_POLYS];

	state_t state_q, state_d;
	logic [1:0]           func_q;
	logic [PB-1:0]        p_q;
	logic                 p_ok_q;
	logic [31:0]          c_q, x_q;
	logic [EXPO_BITS-1:0] e_q;
	logic [CB-1:0]        n_q, i_q, k_q;
	logic                 rd_pend_q, ins_q;
	logic [31:0]          rd_coef_q;
	logic [EXPO_BITS-1:0] rd_expo_q;
	logic [31:0]          acc_q, base_q, sum_q;
	logic [EB-1:0]        bit_q;
	logic                 mphase_q;
	logic [31:0]          value_q;
	logic [4:0]           tcnt_q;
	logic                 status_q;

	// Memory port control
	logic                 rd_en, wr_en;
	logic [AB-1:0]        rd_addr, wr_addr;
	logic [31:0]          wr_coef;
	logic [EXPO_BITS-1:0] wr_expo;

	logic [31:0] mul_a, mul_b, mul_p;
	logic [31:0] base_cur;
	spts_mul32 u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	function automatic logic [AB-1:0] addr_of(logic [PB-1:0] p, logic [CB-1:0] i);
		addr_of = AB'(p) * AB'(MAX_TERMS) + AB'(i);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			coef_mem[wr_addr] <= wr_coef;
			expo_mem[wr_addr] <= wr_expo;
		end
		if (rd_en) begin
			rd_coef_q <= coef_mem[rd_addr];
			rd_expo_q <= expo_mem[rd_addr];
		end
	end

	logic [31:0] sum_add;
	assign sum_add = rd_coef_q + c_q;
	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign m_tdata  = {2'b00, status_q, tcnt_q, value_q};
	// squared base is forwarded in the cycle it leaves the multiplier
	assign base_cur = (state_q == ST_POW && !mphase_q && bit_q != '0) ? mul_p : base_q;
	assign mul_a    = mphase_q ? base_cur : acc_q;
	assign mul_b    = (state_q == ST_MUL) ? rd_coef_q : base_cur;

	// Next state and memory requests
	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		wr_en = 1'b0;
		rd_addr = addr_of(p_q, i_q);
		wr_addr = addr_of(p_q, k_q);
		wr_coef = rd_coef_q;
		wr_expo = rd_expo_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid && s_tready) state_d = ST_SCAN;
			ST_SCAN: begin
				if (!p_ok_q || func_q != FUNC_ADD && func_q != FUNC_EVAL)
					state_d = ST_DONE;
				else if (func_q == FUNC_ADD && c_q == 32'd0)
					state_d = ST_DONE;
				else if (rd_pend_q) begin
					if (func_q == FUNC_EVAL) state_d = ST_POW;
					else if (rd_expo_q > e_q) begin
						if (i_q + CB'(1) < n_q) rd_en = 1'b1;
						else state_d = ST_SHIFT;
					end else if (rd_expo_q == e_q) begin
						if (sum_add != 32'd0) begin
							wr_en = 1'b1;
							wr_addr = addr_of(p_q, i_q);
							wr_coef = sum_add;
							state_d = ST_DONE;
						end else state_d = ST_SHIFT;
					end else state_d = ST_SHIFT;
				end else if (i_q < n_q) rd_en = 1'b1;
				else if (func_q == FUNC_EVAL) state_d = ST_DONE;
				else state_d = ST_SHIFT;
				if (rd_en && rd_pend_q) rd_addr = addr_of(p_q, i_q + CB'(1));
			end
			ST_SHIFT: begin
				// k walks entries moved; rd_pend marks read data valid
				if (ins_q) begin
					if (n_q >= CB'(MAX_TERMS)) state_d = ST_DONE;
					else if (k_q == i_q) begin
						wr_en = 1'b1;
						wr_coef = c_q;
						wr_expo = e_q;
						state_d = ST_DONE;
					end else if (rd_pend_q) wr_en = 1'b1;
					else begin
						rd_en = 1'b1;
						rd_addr = addr_of(p_q, k_q - CB'(1));
					end
				end else begin
					if (k_q + CB'(1) >= n_q) state_d = ST_DONE;
					else if (rd_pend_q) wr_en = 1'b1;
					else begin
						rd_en = 1'b1;
						rd_addr = addr_of(p_q, k_q + CB'(1));
					end
				end
			end
			ST_POW: if (mphase_q && bit_q == EB'(EXPO_BITS - 1)) state_d = ST_MUL;
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				if (i_q + CB'(1) < n_q) begin
					rd_en = 1'b1;
					rd_addr = addr_of(p_q, i_q + CB'(1));
					state_d = ST_SCAN;
				end else state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			rd_pend_q <= 1'b0;
			for (int j = 0; j < NUM_POLYS; j++) cnt_q[j] <= '0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					func_q <= s_tuser;
					p_ok_q <= 32'(s_tdata[4:0]) < NUM_POLYS;
					p_q <= PB'(s_tdata[4:0]);
					c_q <= s_tdata[36:5];
					e_q <= EXPO_BITS'(s_tdata[44:37]);
					x_q <= s_tdata[76:45];
					n_q <= (32'(s_tdata[4:0]) < NUM_POLYS) ? cnt_q[PB'(s_tdata[4:0])] : '0;
					i_q <= '0;
					sum_q <= '0;
					status_q <= 1'b0;
					rd_pend_q <= 1'b0;
				end
				ST_SCAN: begin
					if (state_d == ST_SCAN) begin
						if (rd_en && rd_pend_q) i_q <= i_q + CB'(1);
						rd_pend_q <= rd_en;
					end else begin
						rd_pend_q <= 1'b0;
						if (state_d == ST_POW) begin
							acc_q <= 32'd1;
							base_q <= x_q;
							bit_q <= '0;
							mphase_q <= 1'b0;
						end
						if (state_d == ST_SHIFT) begin
							if (rd_pend_q && rd_expo_q > e_q) i_q <= i_q + CB'(1);
							if (rd_pend_q && rd_expo_q == e_q) begin
								ins_q <= 1'b0;
								k_q <= i_q;
							end else begin
								ins_q <= 1'b1;
								k_q <= n_q;
							end
						end
						if (func_q == FUNC_CLEAR && p_ok_q) cnt_q[p_q] <= '0;
					end
				end
				ST_SHIFT: begin
					if (ins_q && n_q >= CB'(MAX_TERMS)) begin
						// full table: drop the new term
						status_q <= 1'b1;
					end else if (ins_q) begin
						if (k_q == i_q) cnt_q[p_q] <= n_q + CB'(1);
						else if (rd_pend_q) begin
							k_q <= k_q - CB'(1);
							rd_pend_q <= 1'b0;
						end else rd_pend_q <= 1'b1;
					end else begin
						if (k_q + CB'(1) >= n_q) cnt_q[p_q] <= n_q - CB'(1);
						else if (rd_pend_q) begin
							k_q <= k_q + CB'(1);
							rd_pend_q <= 1'b0;
						end else rd_pend_q <= 1'b1;
					end
				end
				ST_POW: begin
					// phase 0: launch acc*base, phase 1: base*base
					mphase_q <= !mphase_q;
					if (mphase_q) begin
						if (rd_expo_q[bit_q]) acc_q <= mul_p;
						bit_q <= bit_q + EB'(1);
					end else if (bit_q != '0) base_q <= mul_p;
				end
				ST_ACC: begin
					sum_q <= sum_q + mul_p;
					i_q <= i_q + CB'(1);
					rd_pend_q <= state_d == ST_SCAN;
				end
				ST_DONE: begin
					m_tvalid <= 1'b1;
					value_q <= (func_q == FUNC_EVAL && p_ok_q) ? sum_q : 32'd0;
					tcnt_q <= p_ok_q ? 5'(cnt_q[p_q]) : 5'd0;
				end
				default: ;
			endcase
		end
	end

	// Handshake checks
	`SPTS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`SPTS_ASSERT_IMP(a_busy_no_accept, state_q != ST_IDLE, !s_tready)
	`SPTS_ASSERT_NXT(a_accept_scan, s_tvalid && s_tready, state_q == ST_SCAN)
endmodule

### rtl/core/spts_mul32.sv
`timescale 1ns / 1ps
// Registered 32x32 multiply, low 32 bits of the product
module spts_mul32 (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule
